// ===== rtl/modinv_pkg.sv =====
// Shared type for the modular inverse unit.
package modinv_pkg;

   // Sign of the current Bezout coefficient; magnitudes are kept unsigned.
   typedef enum logic {
      SIGN_NEG = 1'b0,
      SIGN_POS = 1'b1
   } sign_type;

endpackage

// ===== rtl/modular_inverse_unit_core.sv =====
// Modular inverse unit: extended Euclid over a bit-serial shared divider.
//
// Usage: drive req_modulus and req_operand and raise start while busy is low;
// the item is taken at that clock edge and busy stays high until the result.
// The result appears on rsp_inverse / rsp_exists for exactly one cycle,
// marked by rsp_valid, in the same cycle busy drops; it cannot be held off, so
// capture it then. rsp_inverse is the inverse in 1..modulus-1 with
// rsp_exists set, or 0 with rsp_exists clear when modulus and operand share a
// factor (operand 0 included) or the modulus is below two. An operand above
// the modulus is fine; the first Euclid step swaps it with the modulus and the
// second reduces it. Every Euclid step goes through one restoring divider that
// makes one quotient bit per cycle, and the same cycle folds that bit into the
// coefficient product (shift-add); a step passes through the check, divide and
// update states. A modulus below two answers in the cycle after accept and
// never raises busy.
module modular_inverse_unit_core #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_modulus,
   input  logic [WIDTH-1:0] req_operand,
   output logic             rsp_valid,
   output logic [WIDTH-1:0] rsp_inverse,
   output logic             rsp_exists
);

   localparam int CNT_W = $clog2(WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,    // test remainder for 0 or 1, else start a division
      ST_DIVIDE,   // one quotient bit per cycle
      ST_UPDATE,   // rotate remainders and coefficients
      ST_REDUCE,   // fold coefficient into 0..modulus-1
      ST_REPLY     // apply sign, issue result
   } state_type;

   state_type             state_ff, state_in;
   logic [WIDTH-1:0]      mod_ff, mod_in;
   logic [WIDTH-1:0]      r0_ff, r0_in;       // dividend remainder
   logic [WIDTH-1:0]      r1_ff, r1_in;       // divisor remainder
   logic [WIDTH-1:0]      pm_ff, pm_in;       // previous coefficient magnitude
   logic [WIDTH-1:0]      cm_ff, cm_in;       // current coefficient magnitude
   modinv_pkg::sign_type  sign_ff, sign_in;
   logic [WIDTH-1:0]      rem_ff, rem_in;     // partial remainder of divider
   logic [WIDTH-1:0]      dvd_ff, dvd_in;     // dividend bits, shifted out MSB first
   logic [WIDTH-1:0]      acc_ff, acc_in;     // running q*cm
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]      rsp_inverse_ff, rsp_inverse_in;
   logic                  rsp_exists_ff, rsp_exists_in;

   // Divider step: trial subtract of divisor from shifted partial remainder.
   logic [WIDTH:0]        trial;
   logic                  qbit;

   assign trial = {rem_ff, dvd_ff[WIDTH-1]} - {1'b0, r1_ff};
   assign qbit  = ~trial[WIDTH];

   always_comb begin
      state_in       = state_ff;
      mod_in         = mod_ff;
      r0_in          = r0_ff;
      r1_in          = r1_ff;
      pm_in          = pm_ff;
      cm_in          = cm_ff;
      sign_in        = sign_ff;
      rem_in         = rem_ff;
      dvd_in         = dvd_ff;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_inverse_in = rsp_inverse_ff;
      rsp_exists_in  = rsp_exists_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mod_in  = req_modulus;
               r0_in   = req_modulus;
               r1_in   = req_operand;
               pm_in   = '0;
               cm_in   = WIDTH'(1);
               sign_in = modinv_pkg::SIGN_POS;
               if (req_modulus < WIDTH'(2)) begin
                  // no inverse modulo 0 or 1
                  rsp_valid_in   = 1'b1;
                  rsp_inverse_in = '0;
                  rsp_exists_in  = 1'b0;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (r1_ff == '0) begin
               // gcd above one: not coprime
               rsp_valid_in   = 1'b1;
               rsp_inverse_in = '0;
               rsp_exists_in  = 1'b0;
               state_in       = ST_IDLE;
            end else if (r1_ff == WIDTH'(1)) begin
               state_in = ST_REDUCE;
            end else begin
               rem_in   = '0;
               dvd_in   = r0_ff;
               acc_in   = '0;
               cnt_in   = CNT_W'(WIDTH - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = qbit ? trial[WIDTH-1:0] : {rem_ff[WIDTH-2:0], dvd_ff[WIDTH-1]};
            dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
            // Horner form: q*cm built MSB first, never exceeds the final product
            acc_in = {acc_ff[WIDTH-2:0], 1'b0} + (qbit ? cm_ff : '0);
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            pm_in    = cm_ff;
            cm_in    = acc_ff + pm_ff;
            sign_in  = (sign_ff == modinv_pkg::SIGN_POS) ? modinv_pkg::SIGN_NEG
                                                         : modinv_pkg::SIGN_POS;
            r0_in    = r1_ff;
            r1_in    = rem_ff;
            state_in = ST_CHECK;
         end
         ST_REDUCE: begin
            if (cm_ff >= mod_ff) begin
               cm_in = cm_ff - mod_ff;
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (sign_ff == modinv_pkg::SIGN_NEG && cm_ff != '0) begin
               rsp_inverse_in = mod_ff - cm_ff;
            end else begin
               rsp_inverse_in = cm_ff;
            end
            rsp_exists_in = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mod_ff         <= mod_in;
      r0_ff          <= r0_in;
      r1_ff          <= r1_in;
      pm_ff          <= pm_in;
      cm_ff          <= cm_in;
      sign_ff        <= sign_in;
      rem_ff         <= rem_in;
      dvd_ff         <= dvd_in;
      acc_ff         <= acc_in;
      cnt_ff         <= cnt_in;
      rsp_inverse_ff <= rsp_inverse_in;
      rsp_exists_ff  <= rsp_exists_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_inverse = rsp_inverse_ff;
   assign rsp_exists  = rsp_exists_ff;

   // A result only shows while the unit is idle.
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // A reported inverse lies in 1..modulus-1.
   a_inverse_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_exists) |-> (rsp_inverse != '0 && rsp_inverse < mod_ff))
      else $error("inverse out of range");

   // No inverse means a zero value.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_exists) |-> (rsp_inverse == '0))
      else $error("nonzero value without inverse");

   // An accepted item with a modulus of two or more keeps the unit busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_modulus >= WIDTH'(2)) |=> (busy && !rsp_valid))
      else $error("accepted item did not start work");

endmodule
